FILE: hw/rtl/vde_pkg.sv
// Shared types and constants of the vector distance engine.
`default_nettype none
package vde_pkg;

   localparam int ElemBits = 16;
   localparam int AccBits  = 44;
   localparam int MulBits  = 128;

   localparam logic [2:0] METRIC_L1     = 3'd0;
   localparam logic [2:0] METRIC_L2     = 3'd1;
   localparam logic [2:0] METRIC_L2_SQ  = 3'd2;
   localparam logic [2:0] METRIC_LINF   = 3'd3;
   localparam logic [2:0] METRIC_COSINE = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_NORM = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   localparam logic [AccBits-1:0] ACC_MAX = {AccBits{1'b1}};
   localparam logic [AccBits-1:0] DOT_MAX = {1'b0, {(AccBits-1){1'b1}}};
   localparam logic [AccBits-1:0] DOT_MIN = {1'b1, {(AccBits-1){1'b0}}};
   localparam logic [16:0]        Q16_ONE = 17'd65536;

   typedef struct packed {
      logic signed [ElemBits-1:0] elem_a;
      logic signed [ElemBits-1:0] elem_b;
      logic                       last_element;
   } req_word_type;

   typedef struct packed {
      logic [AccBits-1:0] distance;
      logic [1:0]         status;
   } rsp_word_type;

   // Finished accumulator set of one vector, handed from front to back end.
   typedef struct packed {
      logic [2:0]                metric;
      logic [AccBits-1:0]        diff_sum;
      logic [ElemBits-1:0]       max_abs_diff;
      logic signed [AccBits-1:0] dot_sum;
      logic [AccBits-1:0]        norm_a_sum;
      logic [AccBits-1:0]        norm_b_sum;
      logic                      saturated;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SQRT,
      BK_MUL,
      BK_COS_STEP,
      BK_OUT
   } back_state_type;

   typedef enum logic [1:0] {
      PH_NORM,
      PH_DOT,
      PH_TSQ,
      PH_TP
   } mul_phase_type;

endpackage
`default_nettype wire

FILE: hw/rtl/vector_distance_engine.sv
// Top level of the vector distance engine.
// Streams element pairs of two signed 16-bit vectors, one word per cycle unless
// stalled, and returns one result word per vector (end marked by last_element or by
// the MAX_LEN-th pair). The metric register selects L1 (0), L2 (1), L2 squared (2),
// Linf (3) or cosine (4); change it only while idle. The front end accepts one word
// per clock unless a vector end waits on a full queue, multiplies in one stage and
// accumulates in the next; finished accumulator sets go through a two-entry queue to
// the back end. L1, L2 squared, Linf and unused codes go straight to the output; L2
// runs a 22-step digit square root; cosine uses a bit-serial shift-add multiplier
// that forms the norm product, the squared dot and each step of the 17-step binary
// search. Vectors shorter than the back end latency stall the input through the
// queue. Status: 0 ok, 1 cosine with a zero norm (distance 0), 2 accumulator clipped.
`default_nettype none
module vector_distance_engine
   import vde_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [2:0]   csr_wr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   logic [2:0] metric_ff;
   logic       job_push, job_full, job_pop, job_empty;
   job_type    push_job, pop_job;

   // metric register
   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_L1;
      end else if (csr_wr_en) begin
         metric_ff <= csr_wr_data;
      end
   end

   vde_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock     (clock),
      .reset     (reset),
      .metric    (metric_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .job_push  (job_push),
      .job       (push_job),
      .job_full  (job_full)
   );

   // decouples accumulation from finalization
   vde_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .pop_job  (pop_job),
      .empty    (job_empty)
   );

   vde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_in    (pop_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/vde_queue.sv
// Two-entry queue of finished vectors between front and back end.
`default_nettype none
module vde_queue
   import vde_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue pop while empty");

endmodule
`default_nettype wire

FILE: hw/rtl/vde_front.sv
// Front end: takes element pairs, forms products, accumulates per metric.
`default_nettype none
module vde_front
   import vde_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [2:0]   metric,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              job_push,
   output job_type           job,
   input  wire logic         job_full
);

   localparam int CntW = $clog2(MAX_LEN + 1);

   // stage 1: differences and products
   logic                 s1_valid_ff;
   logic                 s1_end_ff;
   logic [2:0]           s1_metric_ff;
   logic [ElemBits-1:0]  s1_ad_ff;
   logic [31:0]          s1_adsq_ff;
   logic signed [31:0]   s1_ab_ff;
   logic [31:0]          s1_aa_ff;
   logic [31:0]          s1_bb_ff;
   logic [CntW-1:0]      cnt_ff, cnt_in;

   // accumulators
   logic [AccBits-1:0]        diff_ff, diff_in;
   logic [ElemBits-1:0]       max_ff, max_in;
   logic signed [AccBits-1:0] dot_ff, dot_in;
   logic [AccBits-1:0]        na_ff, na_in;
   logic [AccBits-1:0]        nb_ff, nb_in;
   logic                      sat_ff, sat_in;

   logic                 accept, advance, item_end;
   logic signed [16:0]   d;
   logic [16:0]          ad_wide;
   logic [ElemBits-1:0]  ad;
   logic signed [31:0]   ea_wide, eb_wide;
   logic [AccBits:0]     diff_add, na_add, nb_add;
   logic [AccBits:0]     dot_add;
   logic [31:0]          diff_term;

   assign advance   = !(s1_valid_ff && s1_end_ff && job_full);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign item_end  = req_word.last_element || (cnt_ff == CntW'(MAX_LEN - 1));

   always_comb begin
      d       = {req_word.elem_a[ElemBits-1], req_word.elem_a}
              - {req_word.elem_b[ElemBits-1], req_word.elem_b};
      ad_wide = d[16] ? 17'(-d) : 17'(d);
      ad      = ad_wide[ElemBits-1:0];
      ea_wide = 32'(req_word.elem_a);
      eb_wide = 32'(req_word.elem_b);
      cnt_in  = cnt_ff;
      if (accept) begin
         cnt_in = item_end ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_end_ff    <= item_end;
         s1_metric_ff <= metric;
         s1_ad_ff     <= ad;
         s1_adsq_ff   <= 32'(ad) * 32'(ad);
         s1_ab_ff     <= ea_wide * eb_wide;
         s1_aa_ff     <= ea_wide * ea_wide;
         s1_bb_ff     <= eb_wide * eb_wide;
      end
   end

   // accumulate under the metric captured with the word
   always_comb begin
      diff_in  = diff_ff;
      max_in   = max_ff;
      dot_in   = dot_ff;
      na_in    = na_ff;
      nb_in    = nb_ff;
      sat_in   = sat_ff;
      diff_term = (s1_metric_ff == METRIC_L1) ? {16'b0, s1_ad_ff} : s1_adsq_ff;
      diff_add = {1'b0, diff_ff} + {13'b0, diff_term};
      na_add   = {1'b0, na_ff} + {13'b0, s1_aa_ff};
      nb_add   = {1'b0, nb_ff} + {13'b0, s1_bb_ff};
      dot_add  = {dot_ff[AccBits-1], dot_ff} + {{13{s1_ab_ff[31]}}, s1_ab_ff};
      case (s1_metric_ff) inside
         METRIC_L1, METRIC_L2, METRIC_L2_SQ: begin
            if (diff_add[AccBits]) begin
               diff_in = ACC_MAX;
               sat_in  = 1'b1;
            end else begin
               diff_in = diff_add[AccBits-1:0];
            end
         end
         METRIC_LINF: begin
            if (s1_ad_ff > max_ff) max_in = s1_ad_ff;
         end
         METRIC_COSINE: begin
            if (dot_add[AccBits] != dot_add[AccBits-1]) begin
               dot_in = dot_add[AccBits] ? DOT_MIN : DOT_MAX;
               sat_in = 1'b1;
            end else begin
               dot_in = dot_add[AccBits-1:0];
            end
            if (na_add[AccBits]) begin
               na_in  = ACC_MAX;
               sat_in = 1'b1;
            end else begin
               na_in = na_add[AccBits-1:0];
            end
            if (nb_add[AccBits]) begin
               nb_in  = ACC_MAX;
               sat_in = 1'b1;
            end else begin
               nb_in = nb_add[AccBits-1:0];
            end
         end
         default: ;
      endcase
   end

   assign job_push = s1_valid_ff && s1_end_ff && !job_full;

   always_comb begin
      job.metric       = s1_metric_ff;
      job.diff_sum     = diff_in;
      job.max_abs_diff = max_in;
      job.dot_sum      = dot_in;
      job.norm_a_sum   = na_in;
      job.norm_b_sum   = nb_in;
      job.saturated    = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff <= '0;
         max_ff  <= '0;
         dot_ff  <= '0;
         na_ff   <= '0;
         nb_ff   <= '0;
         sat_ff  <= 1'b0;
      end else if (s1_valid_ff && advance) begin
         if (s1_end_ff) begin
            diff_ff <= '0;
            max_ff  <= '0;
            dot_ff  <= '0;
            na_ff   <= '0;
            nb_ff   <= '0;
            sat_ff  <= 1'b0;
         end else begin
            diff_ff <= diff_in;
            max_ff  <= max_in;
            dot_ff  <= dot_in;
            na_ff   <= na_in;
            nb_ff   <= nb_in;
            sat_ff  <= sat_in;
         end
      end
   end

   a_end_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_end_ff && job_full) |=> (s1_valid_ff && s1_end_ff))
      else $error("vector end dropped while queue full");

endmodule
`default_nettype wire

FILE: hw/rtl/vde_back.sv
// Back end: square root, cosine search and result register.
`default_nettype none
module vde_back
   import vde_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_empty,
   input  wire job_type job_in,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_word_type rsp_word
);

   localparam logic [5:0] CNT_NORM = 6'd44;
   localparam logic [5:0] CNT_TSQ  = 6'd17;
   localparam logic [5:0] CNT_TP   = 6'd34;
   localparam logic [4:0] SQRT_STEPS = 5'd22;

   back_state_type state_ff, state_in;
   mul_phase_type  phase_ff, phase_in;
   job_type        job_ff, job_in_reg;

   logic [AccBits-1:0] res_dist_ff, res_dist_in;
   logic [1:0]         res_stat_ff, res_stat_in;

   logic [AccBits-1:0] rad_ff, rad_in;
   logic [25:0]        rem_ff, rem_in;
   logic [21:0]        root_ff, root_in;
   logic [4:0]         it_ff, it_in;

   logic [MulBits-1:0] mx_ff, mx_in;
   logic [AccBits-1:0] my_ff, my_in;
   logic [MulBits-1:0] macc_ff, macc_in;
   logic [5:0]         mcnt_ff, mcnt_in;

   logic [87:0]        prod_p_ff, prod_p_in;
   logic [MulBits-1:0] rhs_ff, rhs_in;
   logic [16:0]        lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;

   logic [25:0]        rem_sh, trial;
   logic [AccBits-1:0] mag;
   logic               dot_neg;
   logic [17:0]        lh_sum;
   logic [1:0]         sat_status;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign dot_neg   = job_ff.dot_sum[AccBits-1];
   assign mag       = dot_neg ? AccBits'(-job_ff.dot_sum) : job_ff.dot_sum;
   assign rem_sh    = {rem_ff[23:0], rad_ff[AccBits-1 -: 2]};
   assign trial     = {2'b0, root_ff, 2'b01};
   assign sat_status = job_ff.saturated ? STATUS_SATURATED : STATUS_OK;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      job_in_reg  = job_ff;
      job_pop     = 1'b0;
      res_dist_in = res_dist_ff;
      res_stat_in = res_stat_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      it_in       = it_ff;
      mx_in       = mx_ff;
      my_in       = my_ff;
      macc_in     = macc_ff;
      mcnt_in     = mcnt_ff;
      prod_p_in   = prod_p_ff;
      rhs_in      = rhs_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      lh_sum      = {1'b0, lo_ff} + {1'b0, hi_ff} + {17'b0, dot_neg};
      unique case (state_ff)
         BK_IDLE: begin
            if (!job_empty) begin
               job_pop    = 1'b1;
               job_in_reg = job_in;
               res_stat_in = (job_in.metric <= METRIC_COSINE && job_in.saturated)
                             ? STATUS_SATURATED : STATUS_OK;
               res_dist_in = '0;
               state_in    = BK_OUT;
               case (job_in.metric) inside
                  METRIC_L1, METRIC_L2_SQ: res_dist_in = job_in.diff_sum;
                  METRIC_LINF: res_dist_in = AccBits'(job_in.max_abs_diff);
                  METRIC_L2: begin
                     rad_in   = job_in.diff_sum;
                     rem_in   = '0;
                     root_in  = '0;
                     it_in    = SQRT_STEPS;
                     state_in = BK_SQRT;
                  end
                  METRIC_COSINE: begin
                     if (job_in.norm_a_sum == '0 || job_in.norm_b_sum == '0) begin
                        res_stat_in = STATUS_ZERO_NORM;
                     end else begin
                        mx_in    = MulBits'(job_in.norm_a_sum);
                        my_in    = job_in.norm_b_sum;
                        macc_in  = '0;
                        mcnt_in  = CNT_NORM;
                        phase_in = PH_NORM;
                        state_in = BK_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_SQRT: begin
            if (it_ff == '0) begin
               res_dist_in = AccBits'(root_ff);
               state_in    = BK_OUT;
            end else begin
               rad_in = rad_ff << 2;
               it_in  = it_ff - 1'b1;
               if (rem_sh >= trial) begin
                  rem_in  = rem_sh - trial;
                  root_in = {root_ff[20:0], 1'b1};
               end else begin
                  rem_in  = rem_sh;
                  root_in = {root_ff[20:0], 1'b0};
               end
            end
         end
         BK_MUL: begin
            if (mcnt_ff != '0) begin
               if (my_ff[0]) macc_in = macc_ff + mx_ff;
               mx_in   = mx_ff << 1;
               my_in   = my_ff >> 1;
               mcnt_in = mcnt_ff - 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_NORM: begin
                     prod_p_in = macc_ff[87:0];
                     mx_in     = MulBits'(mag);
                     my_in     = mag;
                     macc_in   = '0;
                     mcnt_in   = CNT_NORM;
                     phase_in  = PH_DOT;
                  end
                  PH_DOT: begin
                     rhs_in   = macc_ff << 32;
                     lo_in    = '0;
                     hi_in    = Q16_ONE;
                     state_in = BK_COS_STEP;
                  end
                  PH_TSQ: begin
                     mx_in    = MulBits'(prod_p_ff);
                     my_in    = AccBits'(macc_ff[33:0]);
                     macc_in  = '0;
                     mcnt_in  = CNT_TP;
                     phase_in = PH_TP;
                  end
                  PH_TP: begin
                     if (!dot_neg) begin
                        if (macc_ff >= rhs_ff) hi_in = mid_ff;
                        else lo_in = mid_ff + 1'b1;
                     end else begin
                        if (macc_ff <= rhs_ff) lo_in = mid_ff;
                        else hi_in = mid_ff - 1'b1;
                     end
                     state_in = BK_COS_STEP;
                  end
                  default: ;
               endcase
            end
         end
         BK_COS_STEP: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lh_sum[17:1];
               mx_in    = MulBits'(lh_sum[17:1]);
               my_in    = AccBits'(lh_sum[17:1]);
               macc_in  = '0;
               mcnt_in  = CNT_TSQ;
               phase_in = PH_TSQ;
               state_in = BK_MUL;
            end else begin
               res_dist_in = dot_neg ? AccBits'(Q16_ONE) + AccBits'(lo_ff)
                                     : AccBits'(Q16_ONE) - AccBits'(lo_ff);
               res_stat_in = sat_status;
               state_in    = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_word_in.distance = res_dist_ff;
               rsp_word_in.status   = res_stat_ff;
               state_in             = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      job_ff      <= job_in_reg;
      res_dist_ff <= res_dist_in;
      res_stat_ff <= res_stat_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      it_ff       <= it_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      macc_ff     <= macc_in;
      mcnt_ff     <= mcnt_in;
      prod_p_ff   <= prod_p_in;
      rhs_ff      <= rhs_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_word_ff <= rsp_word_in;
   end

   a_zero_norm_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.status == STATUS_ZERO_NORM) |-> rsp_word_ff.distance == '0)
      else $error("zero-norm result with nonzero distance");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_COS_STEP) |-> (hi_ff <= Q16_ONE))
      else $error("cosine search bound out of range");

endmodule
`default_nettype wire
